// ===== rtl/bdeq_pkg.sv =====
// Shared request codes, result status codes and controller interface types.
package bdeq_pkg;

    localparam int WORD_W = 32;

    typedef logic [2:0] op_t;
    typedef logic [2:0] status_t;

    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_PUSH_BACK  = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_BACK   = 3'd3;
    localparam op_t OP_LIST       = 3'd4;

    localparam status_t ST_DONE       = 3'd0;
    localparam status_t ST_OVERFLOW   = 3'd1;
    localparam status_t ST_UNDERFLOW  = 3'd2;
    localparam status_t ST_ELEMENT    = 3'd3;
    localparam status_t ST_LIST_EMPTY = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    walk_start;
        logic    walk_step;
        logic    emit;
        logic    emit_elem;
        status_t emit_status;
        logic    emit_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic walk_last;
    } stat_t;

endpackage

// ===== rtl/bdeq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bdeq_datapath.sv =====
// Datapath: ring store, front index, fill count, listing walker and result register.
module bdeq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bdeq_pkg::cmd_t      cmd,
    input  logic signed [31:0]  value,
    output bdeq_pkg::stat_t     stat,
    output logic                strobe,
    output bdeq_pkg::status_t   status,
    output logic signed [31:0]  element,
    output logic                last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] walk_ptr_reg, walk_ptr_next;
    logic [CNT_W-1:0] walk_cnt_reg, walk_cnt_next;

    logic                         strobe_reg;
    bdeq_pkg::status_t            status_reg;
    logic [bdeq_pkg::WORD_W-1:0]  element_reg;
    logic                         last_reg;

    logic [IDX_W-1:0]            front_dec;
    logic [IDX_W-1:0]            front_inc;
    logic [IDX_W-1:0]            walk_inc;
    logic [SUM_W-1:0]            back_sum;
    logic [IDX_W-1:0]            back_pos;
    logic                        we;
    logic [IDX_W-1:0]            waddr;
    logic [IDX_W-1:0]            raddr;
    logic [bdeq_pkg::WORD_W-1:0] rdata;

    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + IDX_W'(1);
    assign walk_inc  = (walk_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : walk_ptr_reg + IDX_W'(1);

    // The back slot is front + fill, which stays below twice the depth.
    always_comb
    begin
        back_sum = SUM_W'(front_reg) + SUM_W'(fill_reg);
        if (back_sum >= SUM_W'(DEPTH))
        begin
            back_sum = back_sum - SUM_W'(DEPTH);
        end
        back_pos = back_sum[IDX_W-1:0];
    end

    assign we    = cmd.push_front | cmd.push_back;
    assign waddr = cmd.push_front ? front_dec : back_pos;
    assign raddr = cmd.walk_start ? front_reg : walk_ptr_reg;

    bdeq_ram #(
        .WIDTH (bdeq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (value),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        front_next    = front_reg;
        fill_next     = fill_reg;
        walk_ptr_next = walk_ptr_reg;
        walk_cnt_next = walk_cnt_reg;
        if (cmd.push_front)
        begin
            front_next = front_dec;
            fill_next  = fill_reg + CNT_W'(1);
        end
        if (cmd.push_back)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.pop_front)
        begin
            front_next = front_inc;
            fill_next  = fill_reg - CNT_W'(1);
        end
        if (cmd.pop_back)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
        if (cmd.walk_start)
        begin
            walk_ptr_next = front_inc;
            walk_cnt_next = '0;
        end
        if (cmd.walk_step)
        begin
            walk_ptr_next = walk_inc;
            walk_cnt_next = walk_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            fill_reg     <= '0;
            walk_ptr_reg <= '0;
            walk_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            front_reg    <= front_next;
            fill_reg     <= fill_next;
            walk_ptr_reg <= walk_ptr_next;
            walk_cnt_reg <= walk_cnt_next;
            strobe_reg   <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg  <= cmd.emit_status;
            element_reg <= cmd.emit_elem ? rdata : '0;
            last_reg    <= cmd.emit_last;
        end
    end

    assign stat.empty     = (fill_reg == '0);
    assign stat.full      = (fill_reg == CNT_W'(DEPTH));
    assign stat.walk_last = (walk_cnt_reg + CNT_W'(1) == fill_reg);

    assign strobe  = strobe_reg;
    assign status  = status_reg;
    assign element = $signed(element_reg);
    assign last    = last_reg;

endmodule

// ===== rtl/bdeq_ctrl.sv =====
// Controller: decodes requests and sequences the listing walk.
module bdeq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bdeq_pkg::op_t     op,
    input  bdeq_pkg::stat_t   stat,
    output bdeq_pkg::cmd_t    cmd,
    output logic              busy
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic state_reg, state_next;

    always_comb
    begin
        cmd             = '0;
        cmd.emit_status = bdeq_pkg::ST_DONE;
        cmd.emit_last   = 1'b1;
        state_next      = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.emit = 1'b1;
                    unique case (op)
                        bdeq_pkg::OP_PUSH_FRONT:
                        begin
                            if (stat.full)
                            begin
                                cmd.emit_status = bdeq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push_front = 1'b1;
                            end
                        end
                        bdeq_pkg::OP_PUSH_BACK:
                        begin
                            if (stat.full)
                            begin
                                cmd.emit_status = bdeq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push_back = 1'b1;
                            end
                        end
                        bdeq_pkg::OP_POP_FRONT:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit_status = bdeq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                cmd.pop_front = 1'b1;
                            end
                        end
                        bdeq_pkg::OP_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit_status = bdeq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                cmd.pop_back = 1'b1;
                            end
                        end
                        bdeq_pkg::OP_LIST:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit_status = bdeq_pkg::ST_LIST_EMPTY;
                            end
                            else
                            begin
                                // The first read is issued now; results follow from S_LIST.
                                cmd.emit       = 1'b0;
                                cmd.walk_start = 1'b1;
                                state_next     = S_LIST;
                            end
                        end
                        default:
                        begin
                            // Codes with no meaning give a plain done result.
                            cmd.emit_status = bdeq_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_elem   = 1'b1;
                cmd.emit_status = bdeq_pkg::ST_ELEMENT;
                cmd.emit_last   = stat.walk_last;
                cmd.walk_step   = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/bounded_double_ended_queue.sv =====
// Top level of the bounded double-ended queue of signed 32-bit words.
//
//  Channel   Handshake         Ports                     Direction
//  request   start, busy       op, value                 in
//  result    strobe            status, element, last     out
//
// A push or pop request is accepted at a rising edge with start high and busy
// low; its single result word appears on the result ports in the next cycle.
// busy stays low after a push or pop, so requests may follow one per cycle.
// A listing holds busy high while the walker reads one slot a cycle from the
// RAM's single read port; the words emerge one per cycle, front first, after
// passing the RAM read register and the result register.
// Reset clears the front index, fill count, walker and controller; the slot
// RAM is not cleared, as only words from live slots are ever put out.
// Each result word is valid for exactly one cycle, marked by strobe; the
// receiver cannot stall it, so no result is ever held back.
module bounded_double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 op,
    input  logic signed [31:0]         value,
    output logic                       strobe,
    output logic [2:0]                 status,
    output logic signed [31:0]         element,
    output logic                       last
);

    // Commands and status between the controller and the datapath.
    bdeq_pkg::cmd_t  cmd;
    bdeq_pkg::stat_t stat;

    // The controller decodes each request against the full and empty flags and,
    // for a listing, steps the walker until it reaches the back word.
    bdeq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath holds the ring store, the front index and fill count, the
    // listing walker and the registered result word.
    bdeq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .value   (value),
        .stat    (stat),
        .strobe  (strobe),
        .status  (status),
        .element (element),
        .last    (last)
    );

endmodule

// ===== tb/bdeq_checker.sv =====
`timescale 1ns / 100ps
// Checker for the deque: predicts every result word from the requests and compares.
module bdeq_checker
    import bdeq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  op_t                op,
    input  logic signed [31:0] value,
    input  logic               strobe,
    input  status_t            status,
    input  logic signed [31:0] element,
    input  logic               last,
    output int                 outstanding,
    output int                 mismatches,
    output int                 words_checked,
    output int                 full_refusals,
    output int                 empty_refusals
);

    typedef struct {
        status_t            status;
        logic signed [31:0] element;
        logic               last;
    } result_word_t;

    localparam int PRINT_CAP = 40;

    result_word_t       expected_words [$];
    logic signed [31:0] ring [DEPTH];
    int                 head;
    int                 fill;
    int                 printed;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (printed < PRINT_CAP)
        begin
            printed++;
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic queue_word(input status_t st, input logic signed [31:0] elem,
                              input logic fin);
        result_word_t w;
        w.status  = st;
        w.element = elem;
        w.last    = fin;
        expected_words.push_back(w);
    endtask

    // Applies one accepted request to the shadow ring and queues its results.
    task automatic apply_request(input op_t code, input logic signed [31:0] word);
        int i;
        case (code)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill >= DEPTH)
                begin
                    full_refusals++;
                    queue_word(ST_OVERFLOW, '0, 1'b1);
                end
                else
                begin
                    if (code == OP_PUSH_FRONT)
                    begin
                        head       = (head + DEPTH - 1) % DEPTH;
                        ring[head] = word;
                    end
                    else
                    begin
                        ring[(head + fill) % DEPTH] = word;
                    end
                    fill++;
                    queue_word(ST_DONE, '0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (fill == 0)
                begin
                    empty_refusals++;
                    queue_word(ST_UNDERFLOW, '0, 1'b1);
                end
                else
                begin
                    if (code == OP_POP_FRONT)
                        head = (head + 1) % DEPTH;
                    fill--;
                    queue_word(ST_DONE, '0, 1'b1);
                end
            end
            OP_LIST:
            begin
                if (fill == 0)
                    queue_word(ST_LIST_EMPTY, '0, 1'b1);
                else
                    for (i = 0; i < fill; i++)
                        queue_word(ST_ELEMENT, ring[(head + i) % DEPTH], i == fill - 1);
            end
            default:
            begin
                // Undefined codes leave the state alone and are simply acknowledged.
                queue_word(ST_DONE, '0, 1'b1);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_word_t w;
        if (!rst_n)
        begin
            expected_words.delete();
            head           = 0;
            fill           = 0;
            printed        = 0;
            mismatches     = 0;
            words_checked  = 0;
            full_refusals  = 0;
            empty_refusals = 0;
            outstanding   <= 0;
        end
        else
        begin
            if ($isunknown({busy, strobe}))
                report_mismatch("busy or strobe is unknown");
            if (start && !busy)
                apply_request(op, value);
            if (strobe === 1'b1)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("result word (status %0d) with none expected",
                                              status));
                end
                else
                begin
                    w = expected_words.pop_front();
                    words_checked++;
                    if (status !== w.status)
                        report_mismatch($sformatf("word %0d: status %0d, expected %0d",
                                                  words_checked, status, w.status));
                    if (element !== w.element)
                        report_mismatch($sformatf("word %0d: element %0d, expected %0d",
                                                  words_checked, element, w.element));
                    if (last !== w.last)
                        report_mismatch($sformatf("word %0d: last %0b, expected %0b",
                                                  words_checked, last, w.last));
                end
            end
            outstanding <= expected_words.size();
        end
    end

endmodule

// ===== tb/tb_bounded_double_ended_queue.sv =====
`timescale 1ns / 100ps
// Top of the deque testbench: clock, reset, request stimulus and the final verdict.
module tb_bounded_double_ended_queue;
    import bdeq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 480;
    localparam int PHASES       = 6;
    localparam int PER_PHASE    = RANDOM_ITEMS / PHASES;
    // Each segment leans towards pushes or pops for this many requests, which
    // is enough to carry the deque from empty to full and back again.
    localparam int SEGMENT      = 40;
    // Covers a whole listing of a full deque after its acceptance.
    localparam int SETTLE_CYCLES = DEPTH + 6;
    // The slowest correct run has at least 505 requests, each at most DEPTH
    // result words plus an idle gap capped at MAX_GAP, so this limit leaves
    // ample margin.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_GAP      = 40;

    localparam op_t FIRST_UNUSED_OP = OP_LIST + 3'd1;
    localparam op_t LAST_UNUSED_OP  = '1;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    op_t                op    = OP_PUSH_FRONT;
    logic signed [31:0] value = '0;
    logic               busy;
    logic               strobe;
    status_t            status;
    logic signed [31:0] element;
    logic               last;

    int outstanding;
    int mismatches;
    int words_checked;
    int full_refusals;
    int empty_refusals;
    int cycles        = 0;
    int requests_sent = 0;
    int listings_sent = 0;

    // Idle percentages used by the random phases, in turn: a stretch with no
    // idling, a sparse sender and a lightly gapped sender.
    int idle_plan [3] = '{0, 74, 17};

    logic signed [31:0] corner_words [6] = '{32'sh7fffffff, 32'sh80000000, 32'sh00000000,
                                             32'shffffffff, 32'sh55555555, 32'shaaaaaaaa};

    always #1 clk = ~clk;

    bounded_double_ended_queue #(
        .DEPTH(DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .op      (op),
        .value   (value),
        .strobe  (strobe),
        .status  (status),
        .element (element),
        .last    (last)
    );

    // The checker sees exactly the ports the block sees and owns all of the
    // prediction; this module only decides what to send and when.
    bdeq_checker #(
        .DEPTH(DEPTH)
    ) deque_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .value          (value),
        .strobe         (strobe),
        .status         (status),
        .element        (element),
        .last           (last),
        .outstanding    (outstanding),
        .mismatches     (mismatches),
        .words_checked  (words_checked),
        .full_refusals  (full_refusals),
        .empty_refusals (empty_refusals)
    );

    // Watchdog: a hung handshake or a missing result word ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d result words outstanding.",
                     cycles, outstanding);
            $display("FAIL bounded_double_ended_queue");
            $finish;
        end
    end

    // Presents one request word and holds it until the block takes it. The
    // caller is always at a rising edge, and start is only ever raised here,
    // so it never sees a lowering and a raising in the same time step.
    task automatic send_word(input op_t code, input logic signed [31:0] word);
        start <= 1'b1;
        op    <= code;
        value <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
        if (code == OP_LIST)
            listings_sent++;
    endtask

    // Leaves the request channel idle for a random number of cycles; each
    // cycle is idle with the given percentage, so gaps land on every phase of
    // a listing walk as well as between single-word requests.
    task automatic rest_between(input int pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every predicted result word has arrived.
    // The count from the checker is registered, so the task waits for a clock
    // edge first, for the word just accepted to show in it.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Mostly uniform words, with the sign and all-ones corners mixed in often.
    function automatic logic signed [31:0] random_word();
        if ($urandom_range(9) < 4)
            return corner_words[$urandom_range(3)];
        return $urandom();
    endfunction

    // Picks a request, leaning towards pushes while growing and pops while
    // shrinking; listings and the undefined codes are sprinkled through both.
    function automatic op_t pick_op(input logic grow);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return op_t'($urandom_range(LAST_UNUSED_OP, FIRST_UNUSED_OP));
        if (r < 16)
            return OP_LIST;
        if ((r < 79) == grow)
            return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    initial
    begin : stimulus
        int   k;
        int   ph;
        int   n;
        logic grow;
        op_t  code;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty deque first: listing, both pops and each
        // undefined code, all of which must leave it empty.
        send_word(OP_LIST, random_word());
        send_word(OP_POP_FRONT, random_word());
        send_word(OP_POP_BACK, random_word());
        for (k = FIRST_UNUSED_OP; k <= LAST_UNUSED_OP; k++)
            send_word(op_t'(k), $urandom());

        // Fill it from both ends, with the corner words pushed first so that they
        // sit mid-list, then push into the full deque from each end and list it all.
        for (k = 0; k < DEPTH; k++)
            send_word((k % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                      (k < 6) ? corner_words[k] : random_word());
        send_word(OP_PUSH_FRONT, random_word());
        send_word(OP_PUSH_BACK, random_word());
        send_word(OP_LIST, random_word());
        settle();

        // Random part: phases under different idle settings, each draining
        // completely before the next one starts.
        for (ph = 0; ph < PHASES; ph++)
        begin
            n = 0;
            while (n < PER_PHASE)
            begin
                grow = ((n / SEGMENT) % 2) == 0;
                code = pick_op(grow);
                send_word(code, random_word());
                // Undefined codes are merely acknowledged, so they are not
                // counted towards the phase.
                if (code <= OP_LIST)
                    n++;
                rest_between(idle_plan[ph % 3]);
            end
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d listings) in %0d phases; checked %0d result words.",
                 requests_sent, listings_sent, PHASES, words_checked);
        $display("Pushes refused as full: %0d, pops refused as empty: %0d, mismatches: %0d.",
                 full_refusals, empty_refusals, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS bounded_double_ended_queue");
        else
            $display("FAIL bounded_double_ended_queue");
        $finish;
    end

endmodule
